/* hdl/trimmed_mean_window_filter_top_assert.svh */
// Assertion macros used by the filter control module.
`ifndef TRIMMED_MEAN_WINDOW_FILTER_TOP_ASSERT_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define TMWF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define TMWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TMWF_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define TMWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/tmwf_pkg.sv */
package tmwf_pkg;

    localparam int WINDOW      = 8;
    localparam int CHANNELS    = 32;
    localparam int SAMPLE_BITS = 12;
    localparam int TRIMMED     = 2;

    localparam int CH_W   = 5;
    localparam int SMP_W  = 12;
    localparam int FILT_W = 12;

    localparam int ROW_W     = WINDOW * SAMPLE_BITS;
    localparam int ROW_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_EXT_W  = (ROW_IDX_W > CH_W) ? ROW_IDX_W : CH_W;
    localparam int WIN_IDX_W = $clog2(WINDOW);
    localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PROD_W    = 2 * SUM_W + 1;
    localparam int DIV       = WINDOW - TRIMMED;
    // floor(2^SUM_W / DIV): quotient estimate is exact or one low
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((2 ** SUM_W) / DIV);

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [FILT_W-1:0] filtered;
        logic [CH_W-1:0]   out_channel;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic merge;
        logic scan;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

/* hdl/tmwf_ctrl.sv */
`include "trimmed_mean_window_filter_top_assert.svh"

module tmwf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tmwf_pkg::t_status i_status,
    output tmwf_pkg::t_cmd   o_cmd
);
    import tmwf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIX  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.merge = 1'b1;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIX;
            end
            ST_FIX: begin
                // hold until the output register can take the beat
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `TMWF_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, accept, r_state == ST_READ, "accepted beat did not start a read")
    `TMWF_ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, (r_state == ST_SCAN) && i_status.scan_last, r_state == ST_MUL, "scan did not end on last entry")
    `TMWF_ASSERT_NEXT(a_fix_holds, i_clk, i_rst_n, (r_state == ST_FIX) && !i_status.out_free, r_state == ST_FIX, "result dropped while output busy")
    `TMWF_ASSERT_ALWAYS(a_cmd_single, i_clk, i_rst_n, $onehot0(o_cmd), "more than one datapath command")

endmodule

/* hdl/tmwf_dp.sv */
module tmwf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmwf_pkg::t_cmd     i_cmd,
    output tmwf_pkg::t_status  o_status,
    input  tmwf_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tmwf_pkg::t_out_item o_out_item
);
    import tmwf_pkg::*;

    // one row per channel: entry 0 (oldest) in the low bits
    logic [ROW_W-1:0] mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;

    logic [ROW_W-1:0]       r_rdata;
    logic                   r_rd_vld;
    logic [ROW_IDX_W-1:0]   r_idx;
    logic [CH_W-1:0]        r_ch;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic                   r_inr;

    logic [ROW_W-1:0]       r_row, n_row;
    logic [WIN_IDX_W-1:0]   r_cnt;
    logic [SAMPLE_BITS-1:0] r_min, r_max;
    logic [SUM_W-1:0]       r_sum;

    logic [PROD_W-1:0]      r_prod;
    logic [SUM_W-1:0]       r_trim;
    logic                   r_equal;

    logic                   r_out_valid;
    t_out_item              r_out;

    logic [CH_EXT_W-1:0]    ch_ext;
    logic [ROW_IDX_W-1:0]   idx;
    logic                   in_range;
    logic [SAMPLE_BITS-1:0] entry;
    logic [SUM_W-1:0]       trim;
    logic [SUM_W-1:0]       q_est, q_fix, rem;
    logic [FILT_W-1:0]      filt;

    assign ch_ext   = CH_EXT_W'(i_in_item.channel);
    assign idx      = ch_ext[ROW_IDX_W-1:0];
    assign in_range = 32'(i_in_item.channel) < 32'(CHANNELS);

    // shift the new sample in at the newest end, oldest drops out
    assign n_row = {r_smp, (r_rd_vld ? r_rdata[ROW_W-1:SAMPLE_BITS]
                                     : (ROW_W - SAMPLE_BITS)'(0))};

    assign entry = r_row[r_cnt * SAMPLE_BITS +: SAMPLE_BITS];
    assign trim  = r_sum - SUM_W'(r_min) - SUM_W'(r_max);

    assign q_est = r_prod[SUM_W +: SUM_W];
    assign rem   = r_trim - SUM_W'(q_est * SUM_W'(DIV));
    assign q_fix = (rem >= SUM_W'(DIV)) ? q_est + SUM_W'(1) : q_est;

    always_comb begin
        if (!r_inr) begin
            filt = '0;
        end else if (r_equal) begin
            filt = FILT_W'(r_row[SAMPLE_BITS-1:0]);
        end else begin
            filt = FILT_W'(q_fix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rdata <= mem[idx];
        end
        if (i_cmd.merge && r_inr) begin
            mem[r_idx] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.merge && r_inr) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_vld <= r_vld[idx];
            r_idx    <= idx;
            r_ch     <= i_in_item.channel;
            r_smp    <= SAMPLE_BITS'(i_in_item.sample);
            r_inr    <= in_range;
        end
        if (i_cmd.merge) begin
            r_row <= n_row;
            r_cnt <= '0;
            r_min <= '1;
            r_max <= '0;
            r_sum <= '0;
        end
        if (i_cmd.scan) begin
            r_cnt <= r_cnt + WIN_IDX_W'(1);
            r_sum <= r_sum + SUM_W'(entry);
            if (entry < r_min) begin
                r_min <= entry;
            end
            if (entry > r_max) begin
                r_max <= entry;
            end
        end
        if (i_cmd.mul) begin
            r_prod  <= PROD_W'(trim) * PROD_W'(RECIP);
            r_trim  <= trim;
            r_equal <= (r_min == r_max);
        end
        if (i_cmd.emit) begin
            r_out.filtered    <= filt;
            r_out.out_channel <= r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.scan_last = (r_cnt == WIN_IDX_W'(WINDOW - 1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule

/* hdl/trimmed_mean_window_filter_top.sv */
// A beat is accepted in ST_IDLE, then its channel row is read and written back in ST_READ;
// ST_SCAN visits one window entry per cycle, ST_MUL forms the quotient and ST_FIX registers
// the result once the output is free. No new beat is accepted until the result is emitted.
// Reset: synchronous, active low; every channel window reads as all zeros afterwards
// through per-channel valid flags, with no clearing pass.
module trimmed_mean_window_filter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tmwf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tmwf_pkg::t_out_item o_out_item
);
    import tmwf_pkg::*;

    t_cmd    cmd;
    t_status status;

    tmwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tmwf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
